>>> hdl/bounding_sphere_from_box_centre_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bounding sphere block
// Concurrent assertion helpers, clocked on the rising edge of clock and
// disabled during reset.
// ---------------------------------------------------------------------------
`ifndef BOUNDING_SPHERE_FROM_BOX_CENTRE_ASSERT_SVH
`define BOUNDING_SPHERE_FROM_BOX_CENTRE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSBC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSBC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/bsbc_pkg.sv
// ---------------------------------------------------------------------------
// bsbc_pkg
// Constants and types shared by the bounding sphere modules.
// ---------------------------------------------------------------------------
package bsbc_pkg;

   localparam int MAX_POSITIONS = 1024;
   localparam int COORD_BITS    = 16;

   localparam int ADDR_BITS  = $clog2(MAX_POSITIONS);
   localparam int COUNT_BITS = $clog2(MAX_POSITIONS + 1);
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int DIST_BITS  = SQ_BITS + 2;
   localparam int ROOT_BITS  = DIST_BITS / 2;
   localparam int STEP_BITS  = $clog2(ROOT_BITS);

   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] pos_z;
      logic                         is_last;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] centre_x;
      logic signed [COORD_BITS-1:0] centre_y;
      logic signed [COORD_BITS-1:0] centre_z;
      logic        [ROOT_BITS-1:0]  radius;
      logic        [COUNT_BITS-1:0] point_count;
      logic                         overflow;
   } rsp_type;

   typedef struct packed {
      logic start;
   } sqrt_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_sts_type;

   typedef enum logic [4:0] {
      S_LOAD   = 5'b00001,
      S_CENTRE = 5'b00010,
      S_PASS   = 5'b00100,
      S_ROOT   = 5'b01000,
      S_HOLD   = 5'b10000
   } state_type;

endpackage

>>> hdl/bsbc_isqrt.sv
// ---------------------------------------------------------------------------
// bsbc_isqrt
// Floor integer square root, one result bit per cycle (restoring method).
// ---------------------------------------------------------------------------
module bsbc_isqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  bsbc_pkg::sqrt_ctl_type            ctl,
   input  logic [bsbc_pkg::DIST_BITS-1:0]    radicand,
   output bsbc_pkg::sqrt_sts_type            sts,
   output logic [bsbc_pkg::ROOT_BITS-1:0]    root
);
   import bsbc_pkg::*;

   localparam int REM_BITS = ROOT_BITS + 2;

   logic [DIST_BITS-1:0] rad_ff, rad_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [REM_BITS-1:0]  rem_shift;
   logic [REM_BITS-1:0]  trial;

   always_comb begin
      rem_shift = {rem_ff[REM_BITS-3:0], rad_ff[DIST_BITS-1 -: 2]};
      trial     = {root_ff, 2'b01};
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      step_in   = step_ff;
      busy_in   = busy_ff;
      done_in   = done_ff;
      if (ctl.start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         step_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[DIST_BITS-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(ROOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign root     = root_ff;

endmodule

>>> hdl/bounding_sphere_from_box_centre.sv
// ---------------------------------------------------------------------------
// bounding_sphere_from_box_centre
// Stores a vertex set, tracks its bounding box, and returns the sphere
// centred on the box, with the radius the integer floor of the distance to the farthest stored vertex.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  req_      in         req_valid/req_ready    bsbc_pkg::req_type, one vertex
//  rsp_      out        rsp_valid/rsp_ready    bsbc_pkg::rsp_type, one sphere
//
// Vertices load at one per cycle into the vertex RAM while the block is in its
// load state. After the last vertex the block computes the centre, reads each
// stored vertex once through the RAM read port and the distance pipeline, and
// then runs the bit-serial square root; these two set how long the result takes.
// Reset clears the set state; the RAM is not cleared and needs no sweep.
// The result sits in an output register, so loading of the next set can start
// while it waits; a second result stalls in the root stage until it is taken.
// ---------------------------------------------------------------------------
module bounding_sphere_from_box_centre (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bsbc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bsbc_pkg::rsp_type rsp_data
);
   import bsbc_pkg::*;

   `include "bounding_sphere_from_box_centre_assert.svh"

   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic signed [COORD_BITS-1:0] min_ff [3];
   logic signed [COORD_BITS-1:0] min_in [3];
   logic signed [COORD_BITS-1:0] max_ff [3];
   logic signed [COORD_BITS-1:0] max_in [3];
   logic signed [COORD_BITS-1:0] centre_ff [3];
   logic signed [COORD_BITS-1:0] centre_in [3];
   logic                         ovf_ff, ovf_in;

   // Vertex RAM, coordinates packed as {z, y, x}.
   logic [3*COORD_BITS-1:0] vertex_mem [MAX_POSITIONS];
   logic [3*COORD_BITS-1:0] rd_data_ff;
   logic                    wr_en;
   logic [3*COORD_BITS-1:0] wr_data;
   logic                    rd_en;

   logic [COUNT_BITS-1:0] rd_idx_ff, rd_idx_in;
   logic [3:0]            pipe_vld_ff, pipe_vld_in;
   logic [COORD_BITS-1:0] abs_ff [3];
   logic [COORD_BITS-1:0] abs_in [3];
   logic [SQ_BITS-1:0]    sq_ff [3];
   logic [SQ_BITS-1:0]    sq_in [3];
   logic [DIST_BITS-1:0]  sum_ff, sum_in;
   logic [DIST_BITS-1:0]  d2max_ff, d2max_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   sqrt_ctl_type         sq_ctl;
   sqrt_sts_type         sq_sts;
   logic [ROOT_BITS-1:0] root;

   logic                         req_fire;
   logic                         has_room;
   logic                         pass_done;
   logic                         hand_off;
   logic signed [COORD_BITS-1:0] in_coord [3];
   logic signed [COORD_BITS:0]   box_sum [3];
   logic signed [COORD_BITS-1:0] rd_coord [3];
   logic signed [COORD_BITS:0]   diff [3];

   bsbc_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sq_ctl),
      .radicand (d2max_ff),
      .sts      (sq_sts),
      .root     (root)
   );

   assign req_ready = (state_ff == S_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign has_room  = (count_ff < COUNT_BITS'(MAX_POSITIONS));
   assign rd_en     = (state_ff == S_PASS) && (rd_idx_ff < count_ff);
   assign pass_done = (state_ff == S_PASS) && (rd_idx_ff == count_ff) && (pipe_vld_ff == '0);
   assign hand_off  = (state_ff == S_ROOT) && sq_sts.done && (!rsp_valid_ff || rsp_ready);
   assign wr_en     = req_fire && has_room;
   assign wr_data   = {req_data.pos_z, req_data.pos_y, req_data.pos_x};
   assign sq_ctl.start = pass_done;

   assign in_coord[0] = req_data.pos_x;
   assign in_coord[1] = req_data.pos_y;
   assign in_coord[2] = req_data.pos_z;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         box_sum[a]  = {min_ff[a][COORD_BITS-1], min_ff[a]}
                     + {max_ff[a][COORD_BITS-1], max_ff[a]};
         rd_coord[a] = rd_data_ff[a*COORD_BITS +: COORD_BITS];
         diff[a]     = {centre_ff[a][COORD_BITS-1], centre_ff[a]}
                     - {rd_coord[a][COORD_BITS-1], rd_coord[a]};
         abs_in[a]   = diff[a][COORD_BITS] ? COORD_BITS'(-diff[a]) : diff[a][COORD_BITS-1:0];
         sq_in[a]    = abs_ff[a] * abs_ff[a];
      end
      sum_in = DIST_BITS'(sq_ff[0]) + DIST_BITS'(sq_ff[1]) + DIST_BITS'(sq_ff[2]);
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      rd_idx_in   = rd_idx_ff;
      d2max_in    = d2max_ff;
      pipe_vld_in = {pipe_vld_ff[2:0], rd_en};
      for (int a = 0; a < 3; a++) begin
         min_in[a]    = min_ff[a];
         max_in[a]    = max_ff[a];
         centre_in[a] = centre_ff[a];
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (pipe_vld_ff[3] && (sum_ff > d2max_ff)) begin
         d2max_in = sum_ff;
      end

      unique case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (has_room) begin
                  count_in = count_ff + 1'b1;
                  for (int a = 0; a < 3; a++) begin
                     if (in_coord[a] < min_ff[a]) min_in[a] = in_coord[a];
                     if (in_coord[a] > max_ff[a]) max_in[a] = in_coord[a];
                  end
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.is_last) begin
                  state_in = S_CENTRE;
               end
            end
         end
         S_CENTRE: begin
            for (int a = 0; a < 3; a++) begin
               centre_in[a] = box_sum[a][COORD_BITS:1];
            end
            rd_idx_in = '0;
            d2max_in  = '0;
            state_in  = S_PASS;
         end
         S_PASS: begin
            if (rd_en) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (pass_done) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            // The root unit took the start pulse on entering this state and is now busy.
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (hand_off) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.centre_x    = centre_ff[0];
               rsp_data_in.centre_y    = centre_ff[1];
               rsp_data_in.centre_z    = centre_ff[2];
               rsp_data_in.radius      = root;
               rsp_data_in.point_count = count_ff;
               rsp_data_in.overflow    = ovf_ff;
               count_in = '0;
               ovf_in   = 1'b0;
               for (int a = 0; a < 3; a++) begin
                  min_in[a] = COORD_MAX;
                  max_in[a] = COORD_MIN;
               end
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vertex_mem[count_ff[ADDR_BITS-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= vertex_mem[rd_idx_ff[ADDR_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
      for (int a = 0; a < 3; a++) begin
         centre_ff[a] <= centre_in[a];
         abs_ff[a]    <= abs_in[a];
         sq_ff[a]     <= sq_in[a];
      end
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         d2max_ff     <= '0;
         pipe_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            min_ff[a] <= COORD_MAX;
            max_ff[a] <= COORD_MIN;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         d2max_ff     <= d2max_in;
         pipe_vld_ff  <= pipe_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int a = 0; a < 3; a++) begin
            min_ff[a] <= min_in[a];
            max_ff[a] <= max_in[a];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `BSBC_ASSERT_NEXT(a_count_step, req_fire && has_room && !req_data.is_last, count_ff == $past(count_ff) + 1'b1, "stored count did not advance on a stored vertex")
   `BSBC_ASSERT_SAME(a_read_bound, rd_en, rd_idx_ff < count_ff && count_ff != '0, "distance pass read beyond the stored vertices")
   `BSBC_ASSERT_SAME(a_root_floor, hand_off, (DIST_BITS+2)'(root) * (DIST_BITS+2)'(root) <= (DIST_BITS+2)'(d2max_ff), "radius squared exceeds the largest squared distance")
   `BSBC_ASSERT_SAME(a_rsp_count, rsp_valid_ff, rsp_data_ff.point_count != '0, "result transaction carries an empty set")

endmodule
